// ----- rtl/piecewise_saturation_curve_top_defines.svh -----
// ----------------------------------------------------------------------------
// piecewise saturation curve assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_SATURATION_CURVE_TOP_DEFINES_SVH
`define PIECEWISE_SATURATION_CURVE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psc assertion failed");

// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psc assertion failed");

`else

`define PSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg
// types, codes and helpers for the piecewise saturation curve
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_STEP = 2'd1;
    localparam logic [1:0] STATUS_NOT_INCR  = 2'd2;

    // configuration register indexes beyond the curve points
    localparam logic [2:0] CFG_POINTS_IN_USE = 3'd6;
    localparam logic [2:0] CFG_SAT_IND       = 3'd7;

    // configuration reset values
    localparam logic [2:0]  COUNT_RESET   = 3'd1;
    localparam logic [30:0] SAT_IND_RESET = 31'd65536;

    // divider geometry: 42 quotient bits, two per cycle
    localparam int QUO_W     = 42;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // quotient magnitude clamp, 2^40
    localparam logic [QUO_W-1:0] TERM_LIMIT = 42'h100_0000_0000;

    // signed 32-bit range limits
    localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
    localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_PREP   = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_POST   = 8'b0010_0000,
        S_ADD    = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } psc_state_t;

    // saturate to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [42:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'h7fff_ffff;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/piecewise_saturation_curve_top.sv -----
// ----------------------------------------------------------------------------
// piecewise saturation curve: flux to magnetizing current and inductance
// one request at a time, the next one accepted only after the result loads
// into the output register; a curve error skips the divider, a flux past the
// last point takes one division and a flux inside an interval takes two, on
// the shared radix-4 divider
// async active-low reset restores the default curve and clears the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_saturation_curve_top #(
    parameter int MAX_POINTS = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write channel
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    // flux requests
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic signed [31:0] flux_in,
    // results
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic signed [31:0] current_out,
    output      logic signed [31:0] inductance_out,
    output      logic [1:0]         status
);

    import psc_pkg::*;

    localparam logic [2:0] MAXP = 3'(MAX_POINTS);

    // configuration registers
    logic [63:0] point_reg [MAX_POINTS];
    logic [2:0]  count_reg;
    logic [30:0] sat_ind_reg;

    // sequencer and datapath registers
    psc_state_t         state_reg, state_next;
    logic [31:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               interp_reg, interp_next;
    logic               phase_reg, phase_next;
    logic signed [31:0] base_reg, base_next;
    logic [32:0]        a_mag_reg, a_mag_next;
    logic [31:0]        dc_reg, dc_next;
    logic [31:0]        df_mag_reg, df_mag_next;
    logic               df_neg_reg, df_neg_next;
    logic [63:0]        dividend_reg, dividend_next;
    logic [31:0]        divisor_reg, divisor_next;
    logic               term_neg_reg, term_neg_next;
    logic [31:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [QUO_W-1:0]   low_reg, low_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [41:0] term_reg, term_next;
    logic signed [41:0] ind_reg, ind_next;
    logic signed [42:0] sum_reg, sum_next;
    logic [1:0]         stat_reg, stat_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        cur_out_reg, cur_out_next;
    logic [31:0]        ind_out_reg, ind_out_next;
    logic [1:0]         status_out_reg, status_out_next;

    // scan signals
    logic [2:0]         n_eff;
    logic               mono_bad;
    logic               found;
    logic [63:0]        lo_pt;
    logic [63:0]        hi_pt;
    logic [63:0]        last_pt;
    logic signed [33:0] mag_s;
    logic signed [33:0] a_s;
    logic [33:0]        a_abs;
    logic signed [32:0] df_s;
    logic [32:0]        df_abs;
    logic signed [32:0] dc_s;
    logic [31:0]        lsat;

    // divider signals
    logic [32:0]        r1;
    logic               ge1;
    logic [32:0]        r1s;
    logic [32:0]        r2;
    logic               ge2;
    logic [32:0]        r2s;
    logic [QUO_W-1:0]   q_clamp;
    logic signed [41:0] q_signed;
    logic [63:0]        product;
    logic signed [42:0] cur_signed;

    assign cfg_ready      = 1'b1;
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign current_out    = cur_out_reg;
    assign inductance_out = ind_out_reg;
    assign status         = status_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                point_reg[k] <= '0;
            end
            count_reg   <= COUNT_RESET;
            sat_ind_reg <= SAT_IND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POINTS_IN_USE)
            begin
                count_reg <= cfg_data[2:0];
            end
            else if (cfg_index == CFG_SAT_IND)
            begin
                sat_ind_reg <= cfg_data[30:0];
            end
            else
            begin
                for (int k = 0; k < MAX_POINTS; k++)
                begin
                    if (cfg_index == 3'(k))
                    begin
                        point_reg[k] <= cfg_data;
                    end
                end
            end
        end
    end

    // curve check and interval search
    always_comb
    begin
        if (count_reg == 3'd0)
        begin
            n_eff = 3'd1;
        end
        else if (count_reg > MAXP)
        begin
            n_eff = MAXP;
        end
        else
        begin
            n_eff = count_reg;
        end

        mono_bad = 1'b0;
        for (int k = 1; k < MAX_POINTS; k++)
        begin
            if ((3'(k) < n_eff)
                && ($signed(point_reg[k][31:0]) <= $signed(point_reg[k-1][31:0])))
            begin
                mono_bad = 1'b1;
            end
        end

        mag_s = {2'b00, mag_reg};

        // descending so the first matching interval wins
        found = 1'b0;
        lo_pt = '0;
        hi_pt = '0;
        for (int k = MAX_POINTS - 2; k >= 0; k--)
        begin
            if ((3'(k + 1) < n_eff)
                && (mag_s <= $signed({{2{point_reg[k+1][63]}}, point_reg[k+1][63:32]})))
            begin
                found = 1'b1;
                lo_pt = point_reg[k];
                hi_pt = point_reg[k+1];
            end
        end

        last_pt = '0;
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            if (3'(k) == (n_eff - 3'd1))
            begin
                last_pt = point_reg[k];
            end
        end

        if (!found)
        begin
            lo_pt = last_pt;
            hi_pt = last_pt;
        end

        a_s    = mag_s - $signed({{2{lo_pt[63]}}, lo_pt[63:32]});
        a_abs  = a_s[33] ? 34'(-a_s) : 34'(a_s);
        df_s   = $signed({hi_pt[63], hi_pt[63:32]}) - $signed({lo_pt[63], lo_pt[63:32]});
        df_abs = df_s[32] ? 33'(-df_s) : 33'(df_s);
        dc_s   = $signed({hi_pt[31], hi_pt[31:0]}) - $signed({lo_pt[31], lo_pt[31:0]});
        lsat   = (sat_ind_reg == 31'd0) ? 32'd1 : {1'b0, sat_ind_reg};
    end

    // two restoring steps per cycle
    always_comb
    begin
        r1  = {rem_reg, low_reg[QUO_W-1]};
        ge1 = (r1 >= {1'b0, divisor_reg});
        r1s = ge1 ? (r1 - {1'b0, divisor_reg}) : r1;
        r2  = {r1s[31:0], low_reg[QUO_W-2]};
        ge2 = (r2 >= {1'b0, divisor_reg});
        r2s = ge2 ? (r2 - {1'b0, divisor_reg}) : r2;
    end

    // quotient clamp and sign
    always_comb
    begin
        q_clamp  = (ovf_reg || (quo_reg > TERM_LIMIT)) ? TERM_LIMIT : quo_reg;
        q_signed = term_neg_reg ? -$signed(q_clamp) : $signed(q_clamp);
    end

    // 33 by 32 product as one 32 by 32 multiply plus the top bit
    assign product = (64'(a_mag_reg[31:0]) * 64'(dc_reg))
                   + (a_mag_reg[32] ? {dc_reg, 32'd0} : 64'd0);

    assign cur_signed = neg_reg ? -sum_reg : sum_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        interp_next     = interp_reg;
        phase_next      = phase_reg;
        base_next       = base_reg;
        a_mag_next      = a_mag_reg;
        dc_next         = dc_reg;
        df_mag_next     = df_mag_reg;
        df_neg_next     = df_neg_reg;
        dividend_next   = dividend_reg;
        divisor_next    = divisor_reg;
        term_neg_next   = term_neg_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        low_next        = low_reg;
        ovf_next        = ovf_reg;
        cnt_next        = cnt_reg;
        term_next       = term_reg;
        ind_next        = ind_reg;
        sum_next        = sum_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cur_out_next    = cur_out_reg;
        ind_out_next    = ind_out_reg;
        status_out_next = status_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = flux_in[31];
                    mag_next   = flux_in[31] ? 32'(-flux_in) : 32'(flux_in);
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                stat_next  = STATUS_OK;
                phase_next = 1'b0;
                if (mono_bad)
                begin
                    stat_next  = STATUS_NOT_INCR;
                    sum_next   = '0;
                    ind_next   = '0;
                    state_next = S_FINISH;
                end
                else if (found && (df_s == 33'sd0))
                begin
                    stat_next  = STATUS_ZERO_STEP;
                    sum_next   = '0;
                    ind_next   = '0;
                    state_next = S_FINISH;
                end
                else if (found)
                begin
                    interp_next   = 1'b1;
                    base_next     = $signed(lo_pt[31:0]);
                    a_mag_next    = a_abs[32:0];
                    dc_next       = dc_s[31:0];
                    df_mag_next   = df_abs[31:0];
                    df_neg_next   = df_s[32];
                    term_neg_next = a_s[33] ^ df_s[32];
                    state_next    = S_MUL;
                end
                else
                begin
                    // past the last point: saturated inductance line
                    interp_next   = 1'b0;
                    base_next     = $signed(lo_pt[31:0]);
                    dividend_next = {15'd0, a_abs[32:0], 16'd0};
                    divisor_next  = lsat;
                    term_neg_next = a_s[33];
                    ind_next      = $signed({11'd0, sat_ind_reg});
                    state_next    = S_PREP;
                end
            end

            S_MUL:
            begin
                dividend_next = product;
                divisor_next  = df_mag_reg;
                state_next    = S_PREP;
            end

            S_PREP:
            begin
                rem_next   = {10'd0, dividend_reg[63:QUO_W]};
                ovf_next   = ({10'd0, dividend_reg[63:QUO_W]} >= divisor_reg);
                low_next   = dividend_reg[QUO_W-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next = r2s[31:0];
                quo_next = {quo_reg[QUO_W-3:0], ge1, ge2};
                low_next = {low_reg[QUO_W-3:0], 2'b00};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_POST;
                end
            end

            S_POST:
            begin
                if (!phase_reg)
                begin
                    term_next = q_signed;
                    if (interp_reg)
                    begin
                        // segment slope for the inductance
                        dividend_next = {16'd0, df_mag_reg, 16'd0};
                        divisor_next  = dc_reg;
                        term_neg_next = df_neg_reg;
                        phase_next    = 1'b1;
                        state_next    = S_PREP;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
                else
                begin
                    ind_next   = q_signed;
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                sum_next   = 43'(base_reg) + 43'(term_reg);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    cur_out_next    = sat32(cur_signed);
                    ind_out_next    = sat32({ind_reg[41], ind_reg});
                    status_out_next = stat_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        interp_reg     <= interp_next;
        phase_reg      <= phase_next;
        base_reg       <= base_next;
        a_mag_reg      <= a_mag_next;
        dc_reg         <= dc_next;
        df_mag_reg     <= df_mag_next;
        df_neg_reg     <= df_neg_next;
        dividend_reg   <= dividend_next;
        divisor_reg    <= divisor_next;
        term_neg_reg   <= term_neg_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        low_reg        <= low_next;
        ovf_reg        <= ovf_next;
        cnt_reg        <= cnt_next;
        term_reg       <= term_next;
        ind_reg        <= ind_next;
        sum_reg        <= sum_next;
        stat_reg       <= stat_next;
        cur_out_reg    <= cur_out_next;
        ind_out_reg    <= ind_out_next;
        status_out_reg <= status_out_next;
    end

`include "piecewise_saturation_curve_top_defines.svh"

    // an accepted request always starts with the curve scan
    `PSC_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_valid && !in_stall, state_reg == S_SCAN)

    // divider count stays inside its step range
    `PSC_ASSERT_IMPL(a_div_count, clk, rst_n, state_reg == S_DIV, cnt_reg < CNT_W'(DIV_STEPS))

    // the slope division only follows an interpolation
    `PSC_ASSERT_IMPL(a_phase_interp, clk, rst_n, (state_reg == S_PREP) && phase_reg, interp_reg)

    // error results carry zero current and inductance
    `PSC_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && (status != STATUS_OK), (current_out == 32'sd0) && (inductance_out == 32'sd0))

endmodule

`default_nettype wire

// ----- tb/piecewise_saturation_curve_top_tb.sv -----
// ----------------------------------------------------------------------------
// piecewise saturation curve testbench
// drives flux requests through a series of curve settings, predicts current,
// inductance and status per request and checks each result in order while
// both sides idle and stall at random
// ----------------------------------------------------------------------------

localparam int CURVE_POINTS = 6;

// one expected result
typedef struct packed {
    logic [31:0] current;
    logic [31:0] inductance;
    logic [1:0]  status;
} curve_result_t;

// shadow of the curve registers, result prediction and in-order checking
class curve_scoreboard;
    logic [63:0]   point [CURVE_POINTS];
    logic [2:0]    count;
    logic [30:0]   sat_ind;
    curve_result_t awaited [$];
    int            errors;

    function new();
        foreach (point[k])
        begin
            point[k] = '0;
        end
        count   = psc_pkg::COUNT_RESET;
        sat_ind = psc_pkg::SAT_IND_RESET;
        errors  = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [63:0] data);
        if (idx < CURVE_POINTS)
        begin
            point[idx] = data;
        end
        else if (idx == psc_pkg::CFG_POINTS_IN_USE)
        begin
            count = data[2:0];
        end
        else if (idx == psc_pkg::CFG_SAT_IND)
        begin
            sat_ind = data[30:0];
        end
    endfunction

    function longint flux_at(input int k);
        return longint'($signed(point[k][63:32]));
    endfunction

    function longint cur_at(input int k);
        return longint'($signed(point[k][31:0]));
    endfunction

    // a * b / d truncated toward zero, magnitude clamped to 2^40
    function longint scaled_quot(input longint a, input longint b, input longint d);
        longint unsigned ua, ub, ud, q;
        bit              neg;
        neg = (a < 0) ^ (b < 0) ^ (d < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        ud  = (d < 0) ? -d : d;
        q   = (ua * ub) / ud;
        if (q > 64'd1099511627776)
        begin
            q = 64'd1099511627776;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // current, inductance and status for one flux sample
    function curve_result_t curve_lookup(input logic signed [31:0] flux);
        curve_result_t r;
        int            n;
        longint        mag, df, dc, c, lsat;
        bit            neg;
        r.current    = '0;
        r.inductance = '0;
        r.status     = psc_pkg::STATUS_OK;
        n   = (count < 1) ? 1 : ((count > CURVE_POINTS) ? CURVE_POINTS : count);
        neg = flux < 0;
        mag = neg ? -longint'(flux) : longint'(flux);
        // currents must rise strictly over the points in use
        for (int k = 1; k < n; k++)
        begin
            if (cur_at(k) <= cur_at(k - 1))
            begin
                r.status = psc_pkg::STATUS_NOT_INCR;
                return r;
            end
        end
        // first interval whose upper flux covers the magnitude
        for (int k = 0; k + 1 < n; k++)
        begin
            if (mag <= flux_at(k + 1))
            begin
                df = flux_at(k + 1) - flux_at(k);
                dc = cur_at(k + 1) - cur_at(k);
                if (df == 0)
                begin
                    r.status = psc_pkg::STATUS_ZERO_STEP;
                    return r;
                end
                c            = cur_at(k) + scaled_quot(mag - flux_at(k), dc, df);
                r.current    = clamp32(neg ? -c : c);
                r.inductance = clamp32(scaled_quot(df, 65536, dc));
                return r;
            end
        end
        // past the last point
        lsat         = (sat_ind == 0) ? 1 : longint'(sat_ind);
        c            = cur_at(n - 1) + scaled_quot(mag - flux_at(n - 1), 65536, lsat);
        r.current    = clamp32(neg ? -c : c);
        r.inductance = clamp32(longint'(sat_ind));
        return r;
    endfunction

    function void note_flux(input logic signed [31:0] flux);
        awaited.push_back(curve_lookup(flux));
    endfunction

    function void check_result(input logic [31:0] cur, input logic [31:0] ind,
                               input logic [1:0] st);
        curve_result_t e;
        if (awaited.size() == 0)
        begin
            $display("%0t: result with no request pending: current %h inductance %h status %0d",
                     $time, cur, ind, st);
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (cur !== e.current)
        begin
            $display("%0t: current_out expected %h actual %h", $time, e.current, cur);
            errors++;
        end
        if (ind !== e.inductance)
        begin
            $display("%0t: inductance_out expected %h actual %h", $time, e.inductance, ind);
            errors++;
        end
        if (st !== e.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module piecewise_saturation_curve_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 850;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] flux_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] current_out;
    logic signed [31:0] inductance_out;
    logic [1:0]         status;

    curve_scoreboard sb = new();
    logic [63:0]     curve_pts [CURVE_POINTS];
    int              cycle_count = 0;
    bit              no_gaps = 1'b0;
    bit              want_hold = 1'b0;
    int              hold_left = 0;
    int              stall_left = 0;
    int              free_left = 0;
    int              stall_pick;

    piecewise_saturation_curve_top #(
        .MAX_POINTS(CURVE_POINTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .flux_in        (flux_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_out    (current_out),
        .inductance_out (inductance_out),
        .status         (status)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result checking and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(current_out, inductance_out, status);
        end
        if (want_hold)
        begin
            want_hold = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left  = free_left - 1;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 25)
            begin
                free_left = $urandom_range(20, 150);
            end
            else if (stall_pick < 55)
            begin
                stall_left = $urandom_range(1, 3);
            end
            else if (stall_pick < 60)
            begin
                stall_left = $urandom_range(15, 50);
            end
            out_stall <= 1'b0;
        end
    end

    // one register write, valid left high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
    endtask

    // all curve points, then count and saturated inductance
    task automatic load_curve(input logic [63:0] cnt_data, input logic [63:0] sat_data);
        for (int k = 0; k < CURVE_POINTS; k++)
        begin
            write_reg(3'(k), curve_pts[k]);
        end
        write_reg(CFG_POINTS_IN_USE, cnt_data);
        write_reg(CFG_SAT_IND, sat_data);
        cfg_valid <= 1'b0;
    endtask

    // flux request with a random lead-in gap
    task automatic send_flux(input logic signed [31:0] f);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!no_gaps)
        begin
            if (pick >= 92)
            begin
                gap = $urandom_range(10, 40);
            end
            else if (pick >= 60)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        flux_in  <= f;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_flux(f);
    endtask

    // wait for every pending result
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // random curve: mostly well formed, some with a flat flux step,
    // a current dip or fully random points
    task automatic random_curve();
        longint      fx [CURVE_POINTS];
        longint      cx [CURVE_POINTS];
        longint      step_max [5];
        int          kind, fscale, cscale, j, pick;
        logic [2:0]  cnt;
        logic [30:0] sat;
        step_max = '{255, 65535, 64'd4194304, 64'd33554432, 64'd268435456};
        kind   = $urandom_range(0, 9);
        fscale = $urandom_range(0, 4);
        cscale = $urandom_range(0, 4);
        fx[0]  = longint'($urandom_range(0, 32'h2000_0000)) >> $urandom_range(0, 28);
        if ($urandom_range(0, 5) == 0)
        begin
            fx[0] = -fx[0];
        end
        cx[0] = longint'($urandom_range(0, 32'h4000_0000)) - 64'sd536870912;
        for (int k = 1; k < CURVE_POINTS; k++)
        begin
            fx[k] = fx[k - 1] + $urandom_range(1, 32'(step_max[fscale]));
            cx[k] = cx[k - 1] + $urandom_range(1, 32'(step_max[cscale]));
        end
        j = $urandom_range(1, 5);
        if (kind == 1)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                j = 1;
            end
            fx[j] = fx[j - 1];
        end
        else if (kind == 2)
        begin
            cx[j] = cx[j - 1] - $urandom_range(0, 3);
        end
        for (int k = 0; k < CURVE_POINTS; k++)
        begin
            curve_pts[k] = {fx[k][31:0], cx[k][31:0]};
            if (kind == 0)
            begin
                curve_pts[k] = {$urandom, $urandom};
            end
        end
        pick = $urandom_range(0, 9);
        cnt  = (pick == 0) ? 3'd0 : ((pick == 1) ? 3'd7 : 3'($urandom_range(1, 6)));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            sat = '0;
        end
        else if (pick == 1)
        begin
            sat = 31'd1;
        end
        else if (pick == 2)
        begin
            sat = 31'h7fff_ffff;
        end
        else
        begin
            sat = 31'($urandom) >> $urandom_range(0, 30);
        end
        load_curve({$urandom, 29'($urandom), cnt},
                   {$urandom, 1'($urandom), sat});
    endtask

    // flux biased toward the configured intervals and points
    function automatic logic [31:0] random_flux();
        int     pick, k;
        longint lo, hi, v;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, CURVE_POINTS - 2);
        lo   = sb.flux_at(k);
        hi   = sb.flux_at(k + 1);
        if (pick < 35)
        begin
            v = (hi > lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
        end
        else if (pick < 55)
        begin
            v = sb.flux_at($urandom_range(0, CURVE_POINTS - 1)) + $urandom_range(0, 16) - 8;
        end
        else if (pick < 85)
        begin
            return $urandom;
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 1;
                2: v = -1;
                3: v = 64'sd2147483647;
                4: v = -64'sd2147483648;
                default: v = -64'sd2147483647;
            endcase
            return v[31:0];
        end
        if ($urandom_range(0, 2) == 0)
        begin
            v = -v;
        end
        return v[31:0];
    endfunction

    // stimulus
    initial
    begin
        int random_sent;
        int phase;
        int per_phase;
        random_sent = 0;
        phase       = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset curve: single point at the origin, unit saturated inductance
        send_flux(32'h0000_0000);
        send_flux(32'h7fff_ffff);
        send_flux(32'h8000_0000);
        send_flux(32'hffff_0000);
        drain();

        // six-point curve, widest saturated inductance
        curve_pts[0] = 64'h0001_0000_0000_8000;
        curve_pts[1] = 64'h0002_0000_0001_0000;
        curve_pts[2] = 64'h0004_0000_0003_0000;
        curve_pts[3] = 64'h0006_0000_0007_0000;
        curve_pts[4] = 64'h0008_0000_000f_0000;
        curve_pts[5] = 64'h000a_0000_0028_0000;
        load_curve(64'd6, 64'h0000_0000_7fff_ffff);
        send_flux(32'h0000_8000);
        send_flux(32'h0002_0000);
        send_flux(32'h0003_0000);
        send_flux(32'hfffb_0000);
        send_flux(32'h000a_0000);
        send_flux(32'h000b_0000);
        send_flux(32'h7fff_ffff);
        send_flux(32'h8000_0000);
        drain();

        // flat first interval, smallest saturated inductance
        curve_pts[0] = 64'h0002_0000_0001_0000;
        curve_pts[1] = 64'h0002_0000_0002_0000;
        curve_pts[2] = 64'h0003_0000_0003_0000;
        curve_pts[3] = 64'h0005_0000_0004_0000;
        load_curve(64'd4, 64'd1);
        send_flux(32'h0000_0000);
        send_flux(32'h0001_0000);
        send_flux(32'hfffe_0000);
        send_flux(32'h0003_0000);
        send_flux(32'h0009_0000);
        drain();

        // current not rising at the last point, count above range, zero inductance
        curve_pts[0] = 64'h0001_0000_0000_8000;
        curve_pts[1] = 64'h0002_0000_0001_0000;
        curve_pts[2] = 64'h0004_0000_0003_0000;
        curve_pts[3] = 64'h0006_0000_0007_0000;
        curve_pts[4] = 64'h0008_0000_000f_0000;
        curve_pts[5] = 64'h000a_0000_000f_0000;
        load_curve(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_8000_0000);
        send_flux(32'h0001_0000);
        drain();

        // non-rising point left out of use, zero saturated inductance past the end
        write_reg(CFG_POINTS_IN_USE, 64'd5);
        cfg_valid <= 1'b0;
        send_flux(32'h0014_0000);
        send_flux(32'hffec_0000);
        drain();

        // count of zero acts as a single point
        write_reg(CFG_POINTS_IN_USE, 64'd0);
        cfg_valid <= 1'b0;
        send_flux(32'h0003_0000);
        drain();

        // random curves and flux samples
        while (random_sent < RANDOM_ITEMS)
        begin
            random_curve();
            no_gaps = ($urandom_range(0, 4) == 0);
            if (phase == 2)
            begin
                want_hold = 1'b1;
            end
            per_phase = $urandom_range(30, 90);
            repeat (per_phase) send_flux(random_flux());
            random_sent += per_phase;
            drain();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
